@@ sv/ifss_pkg.sv @@
// Package for the integer queue with search and sort.
// Holds command and status codes and field widths; no dependencies.
`timescale 1ns / 1ps
package ifss_pkg;
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int FILL_W   = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH      = 3'd0,
      CMD_POP       = 3'd1,
      CMD_FIND      = 3'd2,
      CMD_SORT_UP   = 3'd3,
      CMD_SORT_DOWN = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] data_out;
      logic [POS_W-1:0]          match_pos;
      logic [FILL_W-1:0]         fill_count;
   } rsp_type;
endpackage

@@ sv/ifss_if.sv @@
// Valid/ready channel interface carrying one word of a given payload type.
// The payload type is a parameter; no package dependency.
`timescale 1ns / 1ps
interface ifss_if #(parameter type PAYLOAD_TYPE = logic) (input logic clock);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/ifss_mem.sv @@
// Entry store of the queue: one write port, one registered read port.
// No package dependency.
`timescale 1ns / 1ps
module ifss_mem #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

@@ sv/integer_fifo_with_search_and_sort_top.sv @@
// Top level of the integer queue with search and sort; uses ifss_pkg, ifss_if, ifss_mem.
// Holds the command sequencer, the queue pointers and the output word register.
`timescale 1ns / 1ps
// A bounded first-in first-out queue of DEPTH signed words held in one
// synchronous memory with registered reads. Each request word is one command
// (push, pop, find, sort ascending, sort descending) and gives exactly one
// response word with status, popped data, match position and fill count.
// The block handles one command at a time. A push passes through S_RESP
// before its response word becomes valid. A pop passes through S_POP_RD,
// S_POP_WAIT and S_RESP, since the head must be read through the memory
// port. Find reads and then compares each entry in turn from the head
// (S_FIND_RD, S_FIND_CHK) and answers on the first hit or after the last
// entry. The sorts are an insertion sort over the one memory: each pass
// takes the entry at position i and compares it with the entries before it,
// moving each out-of-order entry up one place. A new request is taken as
// soon as the block is idle and the previous response word has left the
// output register or is being taken.
module integer_fifo_with_search_and_sort_top #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   ifss_if.sink   req,
   ifss_if.source rsp
);
   import ifss_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_POP_RD, S_POP_WAIT, S_FIND_RD, S_FIND_CHK,
      S_SORT_OUTER, S_SORT_CUR, S_SORT_PREV, S_SORT_CMP, S_RESP
   } state_type;

   state_type             state_ff;
   logic [AW-1:0]         head_ff;
   logic [CW-1:0]         count_ff;
   cmd_type               cmd_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [DATA_WIDTH-1:0] cur_ff;
   logic [CW-1:0]         i_ff;
   logic [CW-1:0]         j_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [CW-1:0]         rd_pos;
   logic [CW-1:0]         wr_pos;
   logic                  out_free;
   logic                  move;
   logic [DATA_WIDTH-1:0] req_wide;

   ifss_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // Map a position from the head to a store index with one compare/subtract.
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
      logic [CW:0] s;
      s = {{(CW+1-AW){1'b0}}, h} + {1'b0, p};
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   // Sign-extend or truncate the 32-bit request value to the store width.
   always_comb begin
      req_wide = DATA_WIDTH'($signed(req.payload.value));
   end

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // Insertion step: previous entry moves up when it is out of order.
   assign move = (cmd_ff == CMD_SORT_DOWN) ? ($signed(rd_data) < $signed(cur_ff))
                                           : ($signed(rd_data) > $signed(cur_ff));

   always_comb begin
      rd_pos = '0;
      unique case (state_ff)
         S_FIND_RD, S_FIND_CHK: rd_pos = i_ff;
         S_SORT_OUTER:          rd_pos = i_ff;
         S_SORT_CUR, S_SORT_PREV, S_SORT_CMP: rd_pos = j_ff - CW'(1);
         default:               rd_pos = '0;
      endcase
      rd_addr = slot(head_ff, rd_pos);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_pos  = j_ff;
      wr_data = cur_ff;
      if (state_ff == S_IDLE && req.valid && out_free
          && req.payload.cmd == CMD_PUSH && count_ff < CW'(DEPTH)) begin
         wr_en   = 1'b1;
         wr_pos  = count_ff;
         wr_data = req_wide;
      end else if (state_ff == S_SORT_CMP) begin
         wr_en = 1'b1;
         if (move && j_ff != '0) begin
            wr_data = rd_data;
         end
      end
      wr_addr = slot(head_ff, wr_pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && out_free) begin
                  cmd_ff <= cmd_type'(req.payload.cmd);
                  val_ff <= req_wide;
                  rsp_ff.data_out  <= '0;
                  rsp_ff.match_pos <= '0;
                  i_ff   <= '0;
                  unique case (req.payload.cmd)
                     CMD_PUSH: begin
                        if (count_ff < CW'(DEPTH)) begin
                           count_ff      <= count_ff + CW'(1);
                           rsp_ff.status <= ST_OK;
                        end else begin
                           rsp_ff.status <= ST_FULL;
                        end
                        state_ff <= S_RESP;
                     end
                     CMD_POP: begin
                        if (count_ff == '0) begin
                           rsp_ff.status <= ST_EMPTY;
                           state_ff      <= S_RESP;
                        end else begin
                           rsp_ff.status <= ST_OK;
                           state_ff      <= S_POP_RD;
                        end
                     end
                     CMD_FIND: begin
                        if (count_ff == '0) begin
                           rsp_ff.status <= ST_NOT_FOUND;
                           state_ff      <= S_RESP;
                        end else begin
                           rsp_ff.status <= ST_OK;
                           state_ff      <= S_FIND_RD;
                        end
                     end
                     CMD_SORT_UP, CMD_SORT_DOWN: begin
                        rsp_ff.status <= ST_OK;
                        i_ff     <= CW'(1);
                        state_ff <= S_SORT_OUTER;
                     end
                     default: begin
                        rsp_ff.status <= ST_OK;
                        state_ff      <= S_RESP;
                     end
                  endcase
               end
            end
            S_POP_RD: state_ff <= S_POP_WAIT;
            S_POP_WAIT: begin
               rsp_ff.data_out <= VALUE_W'(rd_data);
               head_ff  <= slot(head_ff, CW'(1));
               count_ff <= count_ff - CW'(1);
               state_ff <= S_RESP;
            end
            S_FIND_RD: state_ff <= S_FIND_CHK;
            S_FIND_CHK: begin
               if (rd_data == val_ff) begin
                  rsp_ff.match_pos <= POS_W'(i_ff);
                  state_ff         <= S_RESP;
               end else if (i_ff + CW'(1) >= count_ff) begin
                  rsp_ff.status <= ST_NOT_FOUND;
                  state_ff      <= S_RESP;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_FIND_RD;
               end
            end
            S_SORT_OUTER: begin
               if (i_ff >= count_ff) begin
                  state_ff <= S_RESP;
               end else begin
                  j_ff     <= i_ff;
                  state_ff <= S_SORT_CUR;
               end
            end
            S_SORT_CUR: begin
               // On the first step of a pass the read data is entry i, the word
               // being inserted. The address now reads position j-1.
               if (j_ff == i_ff) begin
                  cur_ff <= rd_data;
               end
               state_ff <= S_SORT_PREV;
            end
            S_SORT_PREV: begin
               // Position j-1 is read again so it is ready for the compare.
               state_ff <= S_SORT_CMP;
            end
            S_SORT_CMP: begin
               if (move && j_ff != '0) begin
                  j_ff <= j_ff - CW'(1);
                  if (j_ff == CW'(1)) begin
                     state_ff <= S_SORT_CMP;
                  end else begin
                     state_ff <= S_SORT_CUR;
                  end
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_SORT_OUTER;
               end
            end
            S_RESP: begin
               rsp_ff.fill_count <= FILL_W'(count_ff);
               rsp_valid_ff      <= 1'b1;
               state_ff          <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
